FILE: src/ace_pkg.sv
package ace_pkg;

    localparam logic [31:0] LIFETIME_RST = 32'd300;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]  iface;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] expiry;
    } t_entry;

    typedef struct packed {
        logic load_item;
        logic scan_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

FILE: src/ace_ram.sv
module ace_ram #(
    parameter int WIDTH = 114,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ace_ctrl.sv
module ace_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ace_pkg::t_sts i_sts,
    output ace_pkg::t_cmd o_cmd
);

    ace_pkg::t_state r_state;
    ace_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ace_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ace_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ace_pkg::ST_SCAN;
                end
            end
            ace_pkg::ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ace_pkg::ST_DRAIN;
                end
            end
            ace_pkg::ST_DRAIN: begin
                n_state = ace_pkg::ST_FETCH;
            end
            ace_pkg::ST_FETCH: begin
                n_state = ace_pkg::ST_FINISH;
            end
            ace_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ace_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ace_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ace_pkg::ST_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            ace_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            ace_pkg::ST_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/ace_dp.sv
module ace_dp #(
    parameter int ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ace_pkg::t_cmd i_cmd,
    output ace_pkg::t_sts o_sts,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic [1:0]    i_kind,
    input  logic [1:0]    i_iface_id,
    input  logic [31:0]   i_ip_addr,
    input  logic [47:0]   i_mac_addr,
    input  logic [31:0]   i_now_time,
    input  logic [3:0]    i_entry_index,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output logic          o_hit,
    output logic [3:0]    o_slot,
    output logic          o_out_valid,
    output logic [1:0]    o_out_iface,
    output logic [31:0]   o_out_ip,
    output logic [47:0]   o_out_mac,
    output logic [31:0]   o_out_expiry
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ENT_W = $bits(ace_pkg::t_entry);

    // item registers
    ace_pkg::t_kind r_kind;
    logic [1:0]     r_iface;
    logic [31:0]    r_ip;
    logic [47:0]    r_mac;
    logic [31:0]    r_now;
    logic [3:0]     r_idx;
    logic [31:0]    r_life;
    logic [31:0]    r_new_exp;
    logic [31:0]    n_new_exp;
    logic [32:0]    w_exp_sum;

    // scan state
    logic [IDX_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_match_found;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic [31:0]      r_min_exp;
    logic [IDX_W-1:0] r_min_idx;
    logic [ENTRIES-1:0] r_used;

    ace_pkg::t_entry  w_rdata;
    ace_pkg::t_entry  w_wdata;
    logic [ENT_W-1:0] w_rdata_raw;
    logic             w_rd_used;
    logic             w_live;
    logic             w_key;
    logic [31:0]      w_rd_exp;

    logic [IDX_W+3:0] w_idx_ext;
    logic [IDX_W-1:0] w_idx_addr;
    logic             w_idx_ok;
    logic [IDX_W-1:0] w_tgt;
    logic [IDX_W+3:0] w_tgt_ext;
    logic [3:0]       w_tgt_slot;
    logic             w_tgt_used;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;

    // result
    logic        n_hit;
    logic [3:0]  n_slot;
    logic        n_valid;
    logic [1:0]  n_iface;
    logic [31:0] n_ip;
    logic [47:0] n_mac;
    logic [31:0] n_exp;

    logic        r_res_vld;
    logic        r_hit;
    logic [3:0]  r_slot;
    logic        r_valid;
    logic [1:0]  r_oiface;
    logic [31:0] r_oip;
    logic [47:0] r_omac;
    logic [31:0] r_oexp;

    assign w_exp_sum = {1'b0, r_now} + {1'b0, r_life};
    assign n_new_exp = w_exp_sum[32] ? '1 : w_exp_sum[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind  <= ace_pkg::t_kind'(i_kind);
            r_iface <= i_iface_id;
            r_ip    <= i_ip_addr;
            r_mac   <= i_mac_addr;
            r_now   <= i_now_time;
            r_idx   <= i_entry_index;
        end
        r_new_exp <= n_new_exp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life <= ace_pkg::LIFETIME_RST;
        end else if (i_cfg_wr_en) begin
            r_life <= i_cfg_wr_data;
        end
    end

    assign w_rdata   = ace_pkg::t_entry'(w_rdata_raw);
    assign w_rd_used = r_used[r_rd_idx];
    assign w_live    = w_rd_used && (w_rdata.expiry > r_now);
    assign w_key     = w_live && (w_rdata.iface == r_iface) && (w_rdata.ip == r_ip);
    assign w_rd_exp  = w_rd_used ? w_rdata.expiry : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_rd_vld      <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load_item) begin
                r_cnt         <= '0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_cnt <= r_cnt + IDX_W'(1);
                end
                if (r_rd_vld && w_key) begin
                    r_match_found <= 1'b1;
                end
                if (r_rd_vld && !w_live) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
        if (r_rd_vld && w_key && !r_match_found) begin
            r_match_idx <= r_rd_idx;
        end
        if (r_rd_vld && !w_live && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        // oldest entry, first one wins on ties
        if (r_rd_vld && ((r_rd_idx == '0) || (w_rd_exp < r_min_exp))) begin
            r_min_exp <= w_rd_exp;
            r_min_idx <= r_rd_idx;
        end
    end

    assign o_sts.scan_last = (r_cnt == IDX_W'(ENTRIES - 1));
    assign o_sts.out_free  = !r_res_vld || !i_res_stall;

    assign w_idx_ext  = {{IDX_W{1'b0}}, r_idx};
    assign w_idx_addr = w_idx_ext[IDX_W-1:0];
    assign w_idx_ok   = ({5'd0, r_idx} < 9'(ENTRIES));

    always_comb begin
        unique case (r_kind)
            ace_pkg::KIND_LOOKUP: w_tgt = r_match_idx;
            ace_pkg::KIND_ADD: begin
                if (r_match_found) begin
                    w_tgt = r_match_idx;
                end else if (r_free_found) begin
                    w_tgt = r_free_idx;
                end else begin
                    w_tgt = r_min_idx;
                end
            end
            ace_pkg::KIND_READ:   w_tgt = w_idx_addr;
            ace_pkg::KIND_NOP:    w_tgt = '0;
            default:              w_tgt = '0;
        endcase
    end

    assign w_tgt_ext  = {4'd0, w_tgt};
    assign w_tgt_slot = w_tgt_ext[3:0];
    assign w_tgt_used = ((r_kind != ace_pkg::KIND_READ) || w_idx_ok) ? r_used[w_tgt] : 1'b0;
    assign w_raddr    = i_cmd.scan_rd ? r_cnt : w_tgt;

    always_comb begin
        n_hit   = 1'b0;
        n_slot  = '0;
        n_valid = 1'b0;
        n_iface = '0;
        n_ip    = '0;
        n_mac   = '0;
        n_exp   = '0;
        unique case (r_kind)
            ace_pkg::KIND_LOOKUP: begin
                if (r_match_found) begin
                    n_hit   = 1'b1;
                    n_slot  = w_tgt_slot;
                    n_valid = 1'b1;
                    n_iface = w_rdata.iface;
                    n_ip    = w_rdata.ip;
                    n_mac   = w_rdata.mac;
                    n_exp   = w_rdata.expiry;
                end
            end
            ace_pkg::KIND_ADD: begin
                n_slot  = w_tgt_slot;
                n_valid = 1'b1;
                n_exp   = r_new_exp;
                if (r_match_found) begin
                    n_hit   = 1'b1;
                    n_iface = w_rdata.iface;
                    n_ip    = w_rdata.ip;
                    n_mac   = w_rdata.mac;
                end else begin
                    n_iface = r_iface;
                    n_ip    = r_ip;
                    n_mac   = r_mac;
                end
            end
            ace_pkg::KIND_READ: begin
                n_slot = r_idx;
                if (w_tgt_used) begin
                    n_valid = 1'b1;
                    n_iface = w_rdata.iface;
                    n_ip    = w_rdata.ip;
                    n_mac   = w_rdata.mac;
                    n_exp   = w_rdata.expiry;
                end
            end
            ace_pkg::KIND_NOP: begin
                n_slot = '0;
            end
            default: begin
                n_slot = '0;
            end
        endcase
    end

    assign w_we           = i_cmd.finish && (r_kind == ace_pkg::KIND_ADD);
    assign w_wdata.iface  = n_iface;
    assign w_wdata.ip     = n_ip;
    assign w_wdata.mac    = n_mac;
    assign w_wdata.expiry = n_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_we) begin
            r_used[w_tgt] <= 1'b1;
        end
    end

    ace_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tgt),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_res_vld <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_hit    <= n_hit;
            r_slot   <= n_slot;
            r_valid  <= n_valid;
            r_oiface <= n_iface;
            r_oip    <= n_ip;
            r_omac   <= n_mac;
            r_oexp   <= n_exp;
        end
    end

    assign o_res_valid  = r_res_vld;
    assign o_hit        = r_hit;
    assign o_slot       = r_slot;
    assign o_out_valid  = r_valid;
    assign o_out_iface  = r_oiface;
    assign o_out_ip     = r_oip;
    assign o_out_mac    = r_omac;
    assign o_out_expiry = r_oexp;

endmodule

FILE: src/address_cache_with_expiry_top.sv
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_stall    i_kind .. i_entry_index
// result    out        o_res_valid / i_res_stall  o_hit .. o_out_expiry
// config    in         i_cfg_wr_en                i_cfg_wr_data (entry lifetime)
//
// one request runs a scan of the table through the single read port of the
// entry ram, one entry a cycle, then a read of the chosen entry and, for an
// add request, the write-back.
// synchronous active-low reset marks every entry invalid at once, no sweep.
// the result sits in an output register; a new request is taken while it
// waits, and only the final step, with the write-back of an add, holds until the result is taken.
module address_cache_with_expiry_top #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_iface_id,
    input  logic [31:0] i_ip_addr,
    input  logic [47:0] i_mac_addr,
    input  logic [31:0] i_now_time,
    input  logic [3:0]  i_entry_index,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic        o_hit,
    output logic [3:0]  o_slot,
    output logic        o_out_valid,
    output logic [1:0]  o_out_iface,
    output logic [31:0] o_out_ip,
    output logic [47:0] o_out_mac,
    output logic [31:0] o_out_expiry
);

    ace_pkg::t_cmd w_cmd;
    ace_pkg::t_sts w_sts;

    ace_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ace_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_kind        (i_kind),
        .i_iface_id    (i_iface_id),
        .i_ip_addr     (i_ip_addr),
        .i_mac_addr    (i_mac_addr),
        .i_now_time    (i_now_time),
        .i_entry_index (i_entry_index),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_hit         (o_hit),
        .o_slot        (o_slot),
        .o_out_valid   (o_out_valid),
        .o_out_iface   (o_out_iface),
        .o_out_ip      (o_out_ip),
        .o_out_mac     (o_out_mac),
        .o_out_expiry  (o_out_expiry)
    );

    a_res_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finished request");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_res_valid || !i_res_stall))
        else $error("result register overwritten while stalled");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && w_cmd.scan_rd))
        else $error("scan did not start after request transfer");

    a_no_scan_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!w_cmd.scan_rd && !w_cmd.finish))
        else $error("datapath active while idle");

endmodule
